// ===== design/ffts_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ffts_pkg
// Shared types and codes for the first-fit time slot search block.
// ---------------------------------------------------------------------------
package ffts_pkg;

	// default table depth
	localparam int unsigned FFTS_MAX_INTERVALS = 64;

	localparam int unsigned TIME_W = 32;

	// request kinds
	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// response status codes
	typedef enum logic [1:0] {
		STATUS_ANSWERED = 2'd0,
		STATUS_STORED   = 2'd1,
		STATUS_FULL     = 2'd2,
		STATUS_CLEARED  = 2'd3
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	// request beat
	typedef struct packed {
		logic [1:0]        kind;
		logic [TIME_W-1:0] time_value;
		logic [TIME_W-1:0] length;
	} req_t;

	// response beat
	typedef struct packed {
		logic [TIME_W-1:0] slot_start;
		logic [1:0]        status;
	} rsp_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              done;
		logic [TIME_W-1:0] cand;
		logic [TIME_W-1:0] want;
	} token_t;

endpackage : ffts_pkg
`default_nettype wire

// ===== design/ffts_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ffts_cell
// One slot of the booking table. Holds a start and its saturated end, and
// advances the search token by one booked interval per cycle.
// ---------------------------------------------------------------------------
module ffts_cell
	import ffts_pkg::*;
#(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CNT_W = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [TIME_W-1:0] wr_start,
	input  wire logic [TIME_W-1:0] wr_end,
	input  wire logic [CNT_W-1:0]  count,
	input  wire token_t            tok_in,
	output token_t                 tok_out
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] end_q;
	logic              tok_valid_q;
	logic              tok_done_q;
	logic [TIME_W-1:0] tok_cand_q;
	logic [TIME_W-1:0] tok_want_q;

	logic              active;
	logic              fits;
	logic [TIME_W-1:0] gap;
	logic              done_d;
	logic [TIME_W-1:0] cand_d;

	// stored interval, written on an append to this slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_q <= wr_start;
			end_q   <= wr_end;
		end
	end

	// first-fit step for this interval
	always_comb begin
		active = (IDX < count) && !tok_in.done;
		gap    = start_q - tok_in.cand;
		fits   = (start_q >= tok_in.cand) && (gap >= tok_in.want);
		done_d = tok_in.done;
		cand_d = tok_in.cand;
		if (active) begin
			if (fits) begin
				done_d = 1'b1;
			end else if (end_q > tok_in.cand) begin
				cand_d = end_q;
			end
		end
	end

	// token register towards the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_done_q <= done_d;
		tok_cand_q <= cand_d;
		tok_want_q <= tok_in.want;
	end

	assign tok_out = '{valid: tok_valid_q, done: tok_done_q,
		cand: tok_cand_q, want: tok_want_q};

endmodule : ffts_cell
`default_nettype wire

// ===== design/first_fit_time_slot_search_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// first_fit_time_slot_search_top
// Booking table with a first-fit free slot search over a row of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel req_valid/req_ready/req_data carries append, query and
//   clear beats; response channel rsp_valid/rsp_ready/rsp_data returns one
//   beat for every request.
//   Append and clear are done at the accepting edge, which also registers
//   their response.
//   A query injects a search token into cell 0; it moves one cell per
//   cycle through all MAX_INTERVALS cells. At the end of the row the result
//   is captured in ST_WALK and moved into the response register in ST_DONE
//   once the output is free.
//   One request is in flight at a time: a query occupies the block until
//   its response is loaded; append and clear end at their accepting edge.
//   Reset empties the table (count zero) and drops any response. Stored
//   entries are not cleared; only entries below the count are consulted.
//   While the receiver stalls the response is held in the output register
//   and no new request is taken.
// ---------------------------------------------------------------------------
module first_fit_time_slot_search_top
	import ffts_pkg::*;
#(
	parameter int unsigned MAX_INTERVALS = FFTS_MAX_INTERVALS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req_data,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp_data
);

	localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic [TIME_W-1:0] res_q;

	logic              req_fire;
	logic              out_free;
	logic              load_now;
	logic              load_res;
	rsp_t              now_rsp;
	logic              is_append;
	logic              is_query;
	logic              is_clear;
	logic              full;
	logic [TIME_W:0]   end_sum;
	logic [TIME_W-1:0] end_sat;

	token_t tok [MAX_INTERVALS+1];

	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_fire = req_valid && req_ready;
	assign full     = (count_q == CNT_MAX);

	// decode of the request kind
	always_comb begin
		is_append = 1'b0;
		is_query  = 1'b0;
		is_clear  = 1'b0;
		unique case (req_data.kind)
			KIND_APPEND: is_append = 1'b1;
			KIND_QUERY:  is_query  = 1'b1;
			KIND_CLEAR:  is_clear  = 1'b1;
			default:     ;
		endcase
	end

	// saturated interval end
	assign end_sum = {1'b0, req_data.time_value} + {1'b0, req_data.length};
	assign end_sat = end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];

	// immediate response for append, clear and unused kinds
	always_comb begin
		now_rsp = '{slot_start: '0, status: STATUS_ANSWERED};
		if (is_append) begin
			now_rsp.status = full ? STATUS_FULL : STATUS_STORED;
		end else if (is_clear) begin
			now_rsp.status = STATUS_CLEARED;
		end
	end

	// controller: next state and handshake
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		load_now  = 1'b0;
		load_res  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = out_free;
				if (req_fire) begin
					if (is_query) begin
						state_d = ST_WALK;
					end else begin
						load_now = 1'b1;
					end
				end
			end
			ST_WALK: begin
				if (tok[MAX_INTERVALS].valid) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// table fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (req_fire) begin
			if (is_clear) begin
				count_q <= '0;
			end else if (is_append && !full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// search result capture at the end of the row
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && tok[MAX_INTERVALS].valid) begin
			res_q <= tok[MAX_INTERVALS].cand;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_now || load_res) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_now) begin
			rsp_q <= now_rsp;
		end else if (load_res) begin
			rsp_q <= '{slot_start: res_q, status: STATUS_ANSWERED};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// token injected into the first cell
	assign tok[0] = '{valid: req_fire && is_query, done: 1'b0,
		cand: req_data.time_value, want: req_data.length};

	// row of cells
	for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
		ffts_cell #(
			.INDEX (k),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (req_fire && is_append && !full && (count_q == CNT_W'(k))),
			.wr_start (req_data.time_value),
			.wr_end   (end_sat),
			.count    (count_q),
			.tok_in   (tok[k]),
			.tok_out  (tok[k+1])
		);
	end

endmodule : first_fit_time_slot_search_top
`default_nettype wire
